// ===== sv/afsd_pkg.sv =====
`default_nettype none
package afsd_pkg;

   localparam int MAC_W       = 48;
   localparam int TIME_W      = 32;
   localparam int WINSEC_W    = 16;
   localparam int THRESH_W    = 7;
   localparam int COUNT_OUT_W = 7;

   localparam int WINDOW_DEPTH_DEF    = 64;
   localparam int BLACKLIST_DEPTH_DEF = 64;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WINSEC_W-1:0]    WINSEC_RESET    = 16'd10;
   localparam logic [THRESH_W-1:0]    THRESH_RESET    = 7'd5;
   localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX   = 7'd127;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_SECONDS  = 4'd0,
      CSR_MATCH_THRESHOLD = 4'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BL_SCAN,
      S_APPEND,
      S_AGE_RD,
      S_AGE_CHK,
      S_COUNT,
      S_BL_ADD,
      S_DONE
   } afsd_state_type;

   typedef struct packed {
      logic clear;
      logic compare;
   } afsd_match_ctl_type;

endpackage
`default_nettype wire

// ===== sv/arp_flood_source_detector.sv =====
`default_nettype none
// flow: an accepted word first scans the blacklist, and a hit goes straight to the result; else
// it joins the window, aged-out head entries go, the window is counted and the blacklist may take it
// throughput: one word at a time; req_stall is high until the result is loaded into the output
// register, and both scans run one store entry per cycle through the single comparator
// reset: synchronous, active high; window and blacklist empty, registers at 10 s and 5 frames
module arp_flood_source_detector
   import afsd_pkg::*;
#(
   parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
   parameter int BLACKLIST_DEPTH = BLACKLIST_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [MAC_W-1:0]       req_source_mac,
   input  wire logic [TIME_W-1:0]      req_arrival_seconds,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_verdict_drop,
   output logic                        rsp_attack_detected,
   output logic                        rsp_blacklist_overflow,
   output logic [COUNT_OUT_W-1:0]      rsp_source_count,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
   localparam int BL_AW   = (BLACKLIST_DEPTH > 1) ? $clog2(BLACKLIST_DEPTH) : 1;
   localparam int WF_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int BF_W    = $clog2(BLACKLIST_DEPTH + 1);
   localparam int MAX_D   = (WINDOW_DEPTH > BLACKLIST_DEPTH) ? WINDOW_DEPTH : BLACKLIST_DEPTH;
   localparam int CNT_W   = $clog2(MAX_D + 1);
   localparam int CMP_W   = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

   function automatic logic [WIN_AW-1:0] win_next(input logic [WIN_AW-1:0] p);
      return (p == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   afsd_state_type state_ff, state_in;

   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [WIN_AW-1:0]      ptr_ff, ptr_in;
   logic                   pend_ff, pend_in;
   logic [WIN_AW-1:0]      head_ff, head_in;
   logic [WIN_AW-1:0]      tail_ff, tail_in;
   logic [WF_W-1:0]        win_fill_ff, win_fill_in;
   logic [BF_W-1:0]        bl_fill_ff, bl_fill_in;
   logic [MAC_W-1:0]       mac_ff, mac_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [WINSEC_W-1:0]    winsec_ff, winsec_in;
   logic [THRESH_W-1:0]    thresh_ff, thresh_in;
   logic                   drop_ff, drop_in;
   logic                   attack_ff, attack_in;
   logic                   overflow_ff, overflow_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_drop_ff, rsp_drop_in;
   logic                   rsp_attack_ff, rsp_attack_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   req_accept;
   logic                   csr_write;
   logic                   win_wr_en;
   logic                   bl_wr_en;
   logic [MAC_W-1:0]       win_mac_rd;
   logic [TIME_W-1:0]      win_time_rd;
   logic [MAC_W-1:0]       bl_mac_rd;
   logic [MAC_W-1:0]       match_data;
   logic [CNT_W-1:0]       match_count;
   afsd_match_ctl_type     match_ctl;
   logic [CNT_W-1:0]       scan_limit;
   logic                   scan_more;
   logic                   scan_done;
   logic [TIME_W-1:0]      age;
   logic                   age_out;
   logic                   win_full;
   logic [CMP_W-1:0]       count_cmp;
   logic                   attack_now;
   logic                   rsp_free;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign scan_limit = (state_ff == S_BL_SCAN) ? CNT_W'(bl_fill_ff) : CNT_W'(win_fill_ff);
   assign scan_more  = (scan_idx_ff < scan_limit);
   assign scan_done  = !scan_more && !pend_ff;

   // wrapping age of the head entry
   assign age      = now_ff - win_time_rd;
   assign age_out  = (win_fill_ff != '0) && (age > TIME_W'(winsec_ff));
   assign win_full = (win_fill_ff == WF_W'(WINDOW_DEPTH));

   assign count_cmp  = CMP_W'(match_count);
   assign attack_now = (count_cmp >= CMP_W'(thresh_ff));

   assign match_data = (state_ff == S_BL_SCAN) ? bl_mac_rd : win_mac_rd;

   afsd_ram #(.WIDTH(MAC_W), .DEPTH(WINDOW_DEPTH)) u_win_mac (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (tail_ff),
      .wr_data (mac_ff),
      .rd_addr (ptr_ff),
      .rd_data (win_mac_rd)
   );

   afsd_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW_DEPTH)) u_win_time (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (tail_ff),
      .wr_data (now_ff),
      .rd_addr (head_ff),
      .rd_data (win_time_rd)
   );

   afsd_ram #(.WIDTH(MAC_W), .DEPTH(BLACKLIST_DEPTH)) u_bl_mac (
      .clock   (clock),
      .wr_en   (bl_wr_en),
      .wr_addr (bl_fill_ff[BL_AW-1:0]),
      .wr_data (mac_ff),
      .rd_addr (scan_idx_ff[BL_AW-1:0]),
      .rd_data (bl_mac_rd)
   );

   afsd_match_unit #(.CNT_W(CNT_W)) u_match (
      .clock (clock),
      .reset (reset),
      .ctl   (match_ctl),
      .key   (mac_ff),
      .data  (match_data),
      .count (match_count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_BL_SCAN;
         end
         S_BL_SCAN: begin
            if (scan_done) state_in = (match_count != '0) ? S_DONE : S_APPEND;
         end
         S_APPEND:  state_in = S_AGE_RD;
         S_AGE_RD:  state_in = S_AGE_CHK;
         S_AGE_CHK: state_in = age_out ? S_AGE_RD : S_COUNT;
         S_COUNT: begin
            if (scan_done) state_in = S_BL_ADD;
         end
         S_BL_ADD:  state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      scan_idx_in     = scan_idx_ff;
      ptr_in          = ptr_ff;
      pend_in         = pend_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      win_fill_in     = win_fill_ff;
      bl_fill_in      = bl_fill_ff;
      mac_in          = mac_ff;
      now_in          = now_ff;
      drop_in         = drop_ff;
      attack_in       = attack_ff;
      overflow_in     = overflow_ff;
      win_wr_en       = 1'b0;
      bl_wr_en        = 1'b0;
      match_ctl       = '0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_drop_in     = rsp_drop_ff;
      rsp_attack_in   = rsp_attack_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_count_in    = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            match_ctl.clear = 1'b1;
            scan_idx_in     = '0;
            pend_in         = 1'b0;
            if (req_accept) begin
               mac_in = req_source_mac;
               now_in = req_arrival_seconds;
            end
         end
         S_BL_SCAN: begin
            match_ctl.compare = pend_ff;
            pend_in           = scan_more;
            if (scan_more) scan_idx_in = scan_idx_ff + 1'b1;
            drop_in     = (match_count != '0);
            attack_in   = 1'b0;
            overflow_in = 1'b0;
         end
         S_APPEND: begin
            match_ctl.clear = 1'b1;
            win_wr_en       = 1'b1;
            tail_in         = win_next(tail_ff);
            // full window: oldest word goes out as the new one comes in
            if (win_full) begin
               head_in = win_next(head_ff);
            end else begin
               win_fill_in = win_fill_ff + 1'b1;
            end
         end
         S_AGE_RD: begin
         end
         S_AGE_CHK: begin
            if (age_out) begin
               head_in     = win_next(head_ff);
               win_fill_in = win_fill_ff - 1'b1;
            end else begin
               ptr_in      = head_ff;
               scan_idx_in = '0;
               pend_in     = 1'b0;
            end
         end
         S_COUNT: begin
            match_ctl.compare = pend_ff;
            pend_in           = scan_more;
            if (scan_more) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               ptr_in      = win_next(ptr_ff);
            end
         end
         S_BL_ADD: begin
            attack_in = attack_now;
            if (attack_now) begin
               if (bl_fill_ff < BF_W'(BLACKLIST_DEPTH)) begin
                  bl_wr_en   = 1'b1;
                  bl_fill_in = bl_fill_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_drop_in     = drop_ff;
               rsp_attack_in   = !drop_ff && attack_ff;
               rsp_overflow_in = !drop_ff && overflow_ff;
               if (drop_ff) begin
                  rsp_count_in = '0;
               end else if (count_cmp > CMP_W'(COUNT_OUT_MAX)) begin
                  rsp_count_in = COUNT_OUT_MAX;
               end else begin
                  rsp_count_in = count_cmp[COUNT_OUT_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_comb begin
      winsec_in = winsec_ff;
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_SECONDS:  winsec_in = csr_wdata;
            CSR_MATCH_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         win_fill_ff  <= '0;
         bl_fill_ff   <= '0;
         winsec_ff    <= WINSEC_RESET;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         win_fill_ff  <= win_fill_in;
         bl_fill_ff   <= bl_fill_in;
         winsec_ff    <= winsec_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff     <= scan_idx_in;
      ptr_ff          <= ptr_in;
      mac_ff          <= mac_in;
      now_ff          <= now_in;
      drop_ff         <= drop_in;
      attack_ff       <= attack_in;
      overflow_ff     <= overflow_in;
      rsp_drop_ff     <= rsp_drop_in;
      rsp_attack_ff   <= rsp_attack_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_verdict_drop       = rsp_drop_ff;
   assign rsp_attack_detected    = rsp_attack_ff;
   assign rsp_blacklist_overflow = rsp_overflow_ff;
   assign rsp_source_count       = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      win_fill_ff <= WF_W'(WINDOW_DEPTH))
      else $error("window fill beyond depth");

   a_bl_write_room: assert property (@(posedge clock) disable iff (reset)
      bl_wr_en |-> (bl_fill_ff < BF_W'(BLACKLIST_DEPTH)))
      else $error("blacklist written while full");

   a_count_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COUNT) |-> (win_fill_ff != '0))
      else $error("window empty during count scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result word loaded outside done state");
`endif

endmodule
`default_nettype wire

// ===== sv/afsd_ram.sv =====
`default_nettype none
module afsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/afsd_match_unit.sv =====
`default_nettype none
module afsd_match_unit
   import afsd_pkg::*;
#(
   parameter int CNT_W = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire afsd_match_ctl_type ctl,
   input  wire logic [MAC_W-1:0]   key,
   input  wire logic [MAC_W-1:0]   data,
   output logic      [CNT_W-1:0]   count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // one shared 48-bit comparator, used by both the blacklist and window scans
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.compare && (key == data)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule
`default_nettype wire
